// ===== rtl/core/lis_pkg.sv =====
`timescale 1ns / 1ps

package lis_pkg;

	localparam int VALUE_W = 32;
	localparam int LEN_W   = 7;
	localparam int ADDR_W  = 6;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sample_value;
		logic                      end_of_set;
	} sample_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] seq_value;
		logic [LEN_W-1:0]          seq_length;
		logic                      final_flag;
		logic                      overflow_flag;
	} result_word_t;

	typedef struct packed {
		logic [LEN_W-1:0]  run_length;
		logic [ADDR_W-1:0] predecessor;
	} dp_entry_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] path_value;
		dp_entry_t                 dp;
	} aux_entry_t;

	typedef struct packed {
		logic                      val_we;
		logic [ADDR_W-1:0]         val_waddr;
		logic signed [VALUE_W-1:0] val_wdata;
		logic                      rd_en;
		logic [ADDR_W-1:0]         raddr;
		logic                      dp_we;
		logic                      path_we;
		logic [ADDR_W-1:0]         aux_waddr;
		dp_entry_t                 dp_wdata;
		logic signed [VALUE_W-1:0] path_wdata;
	} mem_req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] val_rdata;
		dp_entry_t                 dp_rdata;
		logic signed [VALUE_W-1:0] path_rdata;
	} mem_rsp_t;

endpackage

// ===== rtl/core/lis_mem.sv =====
`timescale 1ns / 1ps

module lis_mem #(
	parameter int MAX_ITEMS = 64
) (
	input  logic              clk,
	input  lis_pkg::mem_req_t req,
	output lis_pkg::mem_rsp_t rsp
);
	import lis_pkg::*;

	localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	logic signed [VALUE_W-1:0] val_mem [MAX_ITEMS];
	aux_entry_t                aux_mem [MAX_ITEMS];
	logic signed [VALUE_W-1:0] val_rdata_q;
	aux_entry_t                aux_rdata_q;

	always_ff @(posedge clk) begin
		if (req.val_we) begin
			val_mem[req.val_waddr[IW-1:0]] <= req.val_wdata;
		end
		if (req.rd_en) begin
			val_rdata_q <= val_mem[req.raddr[IW-1:0]];
		end
	end

	// The run data and the path field share one array with separate field enables.
	always_ff @(posedge clk) begin
		if (req.dp_we) begin
			aux_mem[req.aux_waddr[IW-1:0]].dp <= req.dp_wdata;
		end
		if (req.path_we) begin
			aux_mem[req.aux_waddr[IW-1:0]].path_value <= req.path_wdata;
		end
		if (req.rd_en) begin
			aux_rdata_q <= aux_mem[req.raddr[IW-1:0]];
		end
	end

	assign rsp.val_rdata  = val_rdata_q;
	assign rsp.dp_rdata   = aux_rdata_q.dp;
	assign rsp.path_rdata = aux_rdata_q.path_value;

endmodule

// ===== rtl/core/lis_seq.sv =====
`timescale 1ns / 1ps

module lis_seq #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  lis_pkg::sample_word_t sample,
	output lis_pkg::mem_req_t     mem_req,
	input  lis_pkg::mem_rsp_t     mem_rsp,
	input  logic                  out_free,
	output logic                  emit_load,
	output lis_pkg::result_word_t emit_word
);
	import lis_pkg::*;

	localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);

	typedef enum logic [3:0] {
		S_LOAD,
		S_FETCH,
		S_LATCH,
		S_SCAN,
		S_WRITE,
		S_WREAD,
		S_WSTORE,
		S_EREAD,
		S_ELOAD
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             count_q;
	logic                      ovf_q;
	logic [IW-1:0]             i_q;
	logic [IW-1:0]             j_q;
	logic signed [VALUE_W-1:0] vi_q;
	logic [LEN_W-1:0]          len_q;
	logic [IW-1:0]             pred_q;
	logic [LEN_W-1:0]          best_len_q;
	logic [IW-1:0]             best_end_q;
	logic                      scan_s1;
	logic [IW-1:0]             j_s1;
	logic [IW-1:0]             pos_q;
	logic [LEN_W-1:0]          k_q;
	logic [LEN_W-1:0]          e_q;

	logic             room;
	logic             more_j;
	logic [LEN_W:0]   cand_len;
	logic             hit;
	logic             longer;
	logic [LEN_W-1:0] next_best_len;
	logic [IW-1:0]    next_best_end;
	logic             last_i;
	logic             last_e;

	assign room     = count_q < CW'(MAX_ITEMS);
	assign more_j   = j_q < i_q;
	assign cand_len = {1'b0, mem_rsp.dp_rdata.run_length} + (LEN_W + 1)'(1);
	assign hit      = scan_s1 && (mem_rsp.val_rdata < vi_q) && (cand_len > {1'b0, len_q});
	assign longer   = len_q > best_len_q;
	assign next_best_len = longer ? len_q : best_len_q;
	assign next_best_end = longer ? i_q : best_end_q;
	assign last_i   = (CW'(i_q) + CW'(1)) == count_q;
	assign last_e   = e_q == (best_len_q - LEN_W'(1));

	assign sample_ready = state_q == S_LOAD;
	assign emit_load    = (state_q == S_ELOAD) && out_free;

	assign emit_word.seq_value     = mem_rsp.path_rdata;
	assign emit_word.seq_length    = best_len_q;
	assign emit_word.final_flag    = last_e;
	assign emit_word.overflow_flag = ovf_q;

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_LOAD: begin
				mem_req.val_we    = sample_valid && room;
				mem_req.val_waddr = ADDR_W'(count_q[IW-1:0]);
				mem_req.val_wdata = sample.sample_value;
			end
			S_FETCH: begin
				mem_req.rd_en = 1'b1;
				mem_req.raddr = ADDR_W'(i_q);
			end
			S_SCAN: begin
				mem_req.rd_en = more_j;
				mem_req.raddr = ADDR_W'(j_q);
			end
			S_WRITE: begin
				mem_req.dp_we                = 1'b1;
				mem_req.aux_waddr            = ADDR_W'(i_q);
				mem_req.dp_wdata.run_length  = len_q;
				mem_req.dp_wdata.predecessor = ADDR_W'(pred_q);
			end
			S_WREAD: begin
				mem_req.rd_en = 1'b1;
				mem_req.raddr = ADDR_W'(pos_q);
			end
			S_WSTORE: begin
				mem_req.path_we    = 1'b1;
				mem_req.aux_waddr  = ADDR_W'(k_q - LEN_W'(1));
				mem_req.path_wdata = mem_rsp.val_rdata;
			end
			S_EREAD: begin
				mem_req.rd_en = 1'b1;
				mem_req.raddr = ADDR_W'(e_q);
			end
			S_LATCH, S_ELOAD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			vi_q       <= '0;
			scan_s1    <= 1'b0;
			j_s1       <= '0;
			best_len_q <= LEN_W'(1);
			best_end_q <= '0;
			pos_q      <= '0;
			k_q        <= '0;
			e_q        <= '0;
			len_q      <= LEN_W'(1);
			pred_q     <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (sample_valid) begin
						if (room) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (sample.end_of_set) begin
							i_q        <= '0;
							best_len_q <= LEN_W'(1);
							best_end_q <= '0;
							state_q    <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_LATCH;
				end
				S_LATCH: begin
					vi_q    <= mem_rsp.val_rdata;
					len_q   <= LEN_W'(1);
					pred_q  <= i_q;
					j_q     <= '0;
					scan_s1 <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					scan_s1 <= more_j;
					j_s1    <= j_q;
					if (more_j) begin
						j_q <= j_q + IW'(1);
					end
					if (hit) begin
						len_q  <= cand_len[LEN_W-1:0];
						pred_q <= j_s1;
					end
					if (!more_j && !scan_s1) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					best_len_q <= next_best_len;
					best_end_q <= next_best_end;
					if (last_i) begin
						pos_q   <= next_best_end;
						k_q     <= next_best_len;
						state_q <= S_WREAD;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_FETCH;
					end
				end
				S_WREAD: begin
					state_q <= S_WSTORE;
				end
				S_WSTORE: begin
					if (mem_rsp.dp_rdata.run_length > LEN_W'(1)) begin
						pos_q <= mem_rsp.dp_rdata.predecessor[IW-1:0];
					end
					k_q <= k_q - LEN_W'(1);
					if (k_q == LEN_W'(1)) begin
						e_q     <= '0;
						state_q <= S_EREAD;
					end else begin
						state_q <= S_WREAD;
					end
				end
				S_EREAD: begin
					state_q <= S_ELOAD;
				end
				S_ELOAD: begin
					if (out_free) begin
						e_q <= e_q + LEN_W'(1);
						if (last_e) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_EREAD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> (len_q != '0 && int'(len_q) <= int'(i_q) + 1))
		else $error("run length out of range for its position");

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.rd_en && (mem_req.dp_we || mem_req.path_we)) |->
		(mem_req.raddr != mem_req.aux_waddr))
		else $error("read and write of the same entry in one cycle");

	a_walk_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WREAD) |-> (k_q != '0 && k_q <= best_len_q))
		else $error("walk-back slot out of range");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |=> $past(state_q) == S_ELOAD && state_q != S_ELOAD)
		else $error("result load did not advance the emitter");

endmodule

// ===== rtl/core/longest_increasing_subsequence_unit.sv =====
`timescale 1ns / 1ps

// Longest strictly increasing subsequence unit.
// The sample channel (sample_valid, sample_ready, sample) takes one signed
// value per word; a word with end_of_set closes the sequence. Up to MAX_ITEMS
// values are kept, later ones are dropped and reported through overflow_flag.
// After the closing word the unit runs the quadratic search over the stored
// values, paced by the single read port of the value and run-length memories,
// which deliver one compare per cycle. A walk back over the predecessors then
// collects the subsequence elements.
// The result channel (result_valid, result_ready, result) then gives the
// subsequence in increasing order, one word at a time; each word
// carries the total length, and the final one has final_flag set.
// While the search or the output runs, sample_ready is low. A stalled result
// word is held in the output register and the unit waits on it.
// After reset the unit holds an empty sequence and is ready for samples.

module longest_increasing_subsequence_unit #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  lis_pkg::sample_word_t sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output lis_pkg::result_word_t result
);
	import lis_pkg::*;

	mem_req_t     mem_req;
	mem_rsp_t     mem_rsp;
	logic         out_free;
	logic         emit_load;
	result_word_t emit_word;
	logic         out_valid_q;
	result_word_t out_word_q;

	lis_mem #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_mem (
		.clk(clk),
		.req(mem_req),
		.rsp(mem_rsp)
	);

	lis_seq #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.mem_req(mem_req),
		.mem_rsp(mem_rsp),
		.out_free(out_free),
		.emit_load(emit_load),
		.emit_word(emit_word)
	);

	assign out_free = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_word_q <= emit_word;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_word_q;

endmodule
